// ===== rtl/bst_pkg.sv =====
`timescale 1ns / 1ps

package bst_pkg;

  // one beat of the input channel
  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } bst_in_t;

  // one beat of the result channel
  typedef struct packed {
    logic [3:0]        event_res;
    logic signed [63:0] value;
    logic [7:0]        payload;
    logic [5:0]        depth;
    logic              is_key;
    logic              string_last;
    logic [1:0]        status;
  } bst_out_t;

  typedef enum logic [2:0] {
    M_ELEM,
    M_INT_START,
    M_INT_DIGITS,
    M_STR_LEN,
    M_STR_BODY,
    M_DONE,
    M_ERR
  } mode_t;

  // context of the innermost open container
  typedef enum logic [1:0] {
    CTX_LIST = 2'd0,
    CTX_KEY  = 2'd1,
    CTX_VAL  = 2'd2,
    CTX_TOP  = 2'd3
  } ctx_t;

  typedef enum logic [3:0] {
    EV_NONE  = 4'd0,
    EV_DICT  = 4'd1,
    EV_LIST  = 4'd2,
    EV_CLOSE = 4'd3,
    EV_INT   = 4'd4,
    EV_HDR   = 4'd5,
    EV_BYTE  = 4'd6,
    EV_ERR   = 4'd8
  } ev_t;

  localparam logic [1:0] ST_BUSY = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_L     = 8'h6c;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

endpackage

// ===== rtl/bst_ram.sv =====
`timescale 1ns / 1ps

module bst_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bencode_stream_tokenizer.sv =====
`timescale 1ns / 1ps
// path: an accepted byte is held in the input stage, and its token is then registered into out_data
// throughput: one byte per cycle while out_stall is low; the next state (mode, top of stack,
//   accumulator) is computed combinationally, so a byte may enter at every edge without a stall
// reset: synchronous active-low rst_n empties both stages and returns the parser to
//   expecting a top-level value with no open containers; the stack store needs no clearing

module bencode_stream_tokenizer #(
  parameter int MAX_DEPTH = 32,
  parameter int LEN_BITS  = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bst_pkg::bst_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output bst_pkg::bst_out_t out_data
);

  import bst_pkg::*;

  // depth counter holds 0..MAX_DEPTH, stack store addresses 0..MAX_DEPTH-1
  localparam int DW = $clog2(MAX_DEPTH + 1);
  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  // input stage
  logic     s1_valid_r;
  bst_in_t  s1_data_r;

  // result stage
  logic     out_valid_r;
  bst_out_t out_data_r;
  bst_out_t res_nxt;

  // parser state
  mode_t               mode_r,  mode_nxt;
  logic [DW-1:0]       depth_r, depth_nxt;
  ctx_t                top_r,   top_nxt;   // context of the innermost container
  logic [63:0]         acc_r,   acc_nxt;
  logic                neg_r,   neg_nxt;
  logic [LEN_BITS-1:0] rem_r,   rem_nxt;
  logic                skey_r,  skey_nxt;

  // stack store: entries below the top, top itself lives in top_r
  logic          push;
  logic          byp_r;
  ctx_t          byp_val_r;
  logic [1:0]    ram_rdata;
  logic [DW-1:0] waddr_full;
  logic [DW-1:0] raddr_full;
  ctx_t          second;

  logic          advance;

  // datapath helpers
  logic [7:0]          b;
  logic [7:0]          bsub;
  logic [3:0]          dval;
  logic                is_dig;
  ctx_t                ctx_cur;
  logic [63:0]         acc_step;
  logic [LEN_BITS+3:0] rem_wide;
  logic [LEN_BITS+3:0] rem_step;
  logic                rem_ovf;
  logic [LEN_BITS-1:0] rem_dec;
  logic [15:0]         depth_ext;

  ev_t         ev;
  logic [63:0] val;
  logic [7:0]  pay;
  logic        key_o;
  logic        slast;

  // ---------------------------------------------------------------------------
  // handshake: the input stage moves on whenever the result stage is empty or
  // its beat is taken this cycle, so a byte in the input stage is held while a result waits
  // ---------------------------------------------------------------------------
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
  end

  // ---------------------------------------------------------------------------
  // stack store; the entry just below the top is read every cycle at the
  // address that follows from the next depth, a push bypasses the store
  // ---------------------------------------------------------------------------
  assign waddr_full = depth_r - DW'(1);
  assign raddr_full = depth_nxt - DW'(2);

  bst_ram #(
    .WIDTH (2),
    .DEPTH (MAX_DEPTH),
    .AW    (AW)
  ) u_stack (
    .clk   (clk),
    .we    (push && (depth_r != '0)),
    .waddr (waddr_full[AW-1:0]),
    .wdata (top_r),
    .raddr (raddr_full[AW-1:0]),
    .rdata (ram_rdata)
  );

  // the old top is written at the same edge that registers its read, so after a push the read is stale
  assign second = byp_r ? byp_val_r : ctx_t'(ram_rdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else begin
      byp_r <= push;
    end
  end

  always_ff @(posedge clk) begin
    byp_val_r <= top_r;
  end

  // ---------------------------------------------------------------------------
  // byte decode and arithmetic
  // ---------------------------------------------------------------------------
  assign b       = s1_data_r.byte_in;
  assign bsub    = b - CH_0;
  assign dval    = bsub[3:0];
  assign is_dig  = (b >= CH_0) && (b <= CH_9);
  assign ctx_cur = (depth_r == '0) ? CTX_TOP : top_r;

  // times ten by shift and add, wraps modulo 2^64
  assign acc_step = {acc_r[60:0], 3'b000} + {acc_r[62:0], 1'b0} + 64'(dval);

  // length grows in four extra bits so an overflow past LEN_BITS shows up
  assign rem_wide = (LEN_BITS + 4)'(rem_r);
  assign rem_step = (rem_wide << 3) + (rem_wide << 1) + (LEN_BITS + 4)'(dval);
  assign rem_ovf  = |rem_step[LEN_BITS+3:LEN_BITS];
  assign rem_dec  = (rem_r != '0) ? rem_r - LEN_BITS'(1) : rem_r;

  // ---------------------------------------------------------------------------
  // next state and token
  // ---------------------------------------------------------------------------
  always_comb begin
    mode_nxt  = mode_r;
    depth_nxt = depth_r;
    top_nxt   = top_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    rem_nxt   = rem_r;
    skey_nxt  = skey_r;
    push      = 1'b0;
    ev        = EV_NONE;
    val       = '0;
    pay       = '0;
    key_o     = 1'b0;
    slast     = 1'b0;

    if (advance) begin
      unique case (mode_r)
        M_ELEM: begin
          priority if ((ctx_cur == CTX_LIST || ctx_cur == CTX_KEY) && b == CH_E) begin
            // close: pop, then the parent (if any) has finished a value
            depth_nxt = depth_r - DW'(1);
            ev        = EV_CLOSE;
            if (depth_r == DW'(1)) begin
              mode_nxt = M_DONE;
            end else begin
              top_nxt  = (second == CTX_VAL) ? CTX_KEY : second;
              mode_nxt = M_ELEM;
            end
          end else if (ctx_cur == CTX_KEY) begin
            priority if (is_dig) begin
              skey_nxt = 1'b1;
              rem_nxt  = LEN_BITS'(dval);
              mode_nxt = M_STR_LEN;
            end else if (b == CH_COLON) begin
              // bare colon stands for an empty key
              skey_nxt = 1'b1;
              rem_nxt  = '0;
              ev       = EV_HDR;
              key_o    = 1'b1;
              slast    = 1'b1;
              top_nxt  = CTX_VAL;
              mode_nxt = M_ELEM;
            end else begin
              mode_nxt = M_ERR;
            end
          end else if (b == CH_D || b == CH_L) begin
            if (depth_r >= DW'(MAX_DEPTH)) begin
              mode_nxt = M_ERR;
            end else begin
              push      = 1'b1;
              top_nxt   = (b == CH_D) ? CTX_KEY : CTX_LIST;
              depth_nxt = depth_r + DW'(1);
              ev        = (b == CH_D) ? EV_DICT : EV_LIST;
            end
          end else if (b == CH_I) begin
            acc_nxt  = '0;
            neg_nxt  = 1'b0;
            mode_nxt = M_INT_START;
          end else if (is_dig) begin
            skey_nxt = 1'b0;
            rem_nxt  = LEN_BITS'(dval);
            mode_nxt = M_STR_LEN;
          end else begin
            mode_nxt = M_ERR;
          end
        end

        M_INT_START, M_INT_DIGITS: begin
          priority if (is_dig) begin
            acc_nxt  = acc_step;
            mode_nxt = M_INT_DIGITS;
          end else if (b == CH_MINUS && mode_r == M_INT_START) begin
            neg_nxt  = 1'b1;
            mode_nxt = M_INT_DIGITS;
          end else if (b == CH_E) begin
            ev  = EV_INT;
            val = neg_r ? 64'd0 - acc_r : acc_r;
            if (depth_r == '0) begin
              mode_nxt = M_DONE;
            end else begin
              if (top_r == CTX_VAL) begin
                top_nxt = CTX_KEY;
              end
              mode_nxt = M_ELEM;
            end
          end else begin
            mode_nxt = M_ERR;
          end
        end

        M_STR_LEN: begin
          priority if (is_dig) begin
            if (rem_ovf) begin
              mode_nxt = M_ERR;
            end else begin
              rem_nxt = rem_step[LEN_BITS-1:0];
            end
          end else if (b == CH_COLON) begin
            ev    = EV_HDR;
            val   = 64'(rem_r);
            key_o = skey_r;
            if (rem_r == '0) begin
              slast = 1'b1;
              if (skey_r && depth_r != '0) begin
                top_nxt  = CTX_VAL;
                mode_nxt = M_ELEM;
              end else if (depth_r == '0) begin
                mode_nxt = M_DONE;
              end else begin
                if (top_r == CTX_VAL) begin
                  top_nxt = CTX_KEY;
                end
                mode_nxt = M_ELEM;
              end
            end else begin
              mode_nxt = M_STR_BODY;
            end
          end else begin
            mode_nxt = M_ERR;
          end
        end

        M_STR_BODY: begin
          ev      = EV_BYTE;
          pay     = b;
          key_o   = skey_r;
          rem_nxt = rem_dec;
          if (rem_dec == '0) begin
            slast = 1'b1;
            if (skey_r && depth_r != '0) begin
              top_nxt  = CTX_VAL;
              mode_nxt = M_ELEM;
            end else if (depth_r == '0) begin
              mode_nxt = M_DONE;
            end else begin
              if (top_r == CTX_VAL) begin
                top_nxt = CTX_KEY;
              end
              mode_nxt = M_ELEM;
            end
          end
        end

        M_DONE: begin
          // trailing bytes ignored
        end

        M_ERR: begin
          mode_nxt = M_ERR;
        end

        default: begin
          mode_nxt = M_ERR;
        end
      endcase

      // input ending before the document closes
      if (s1_data_r.last_byte && mode_nxt != M_DONE) begin
        mode_nxt = M_ERR;
      end

      if (mode_nxt == M_ERR) begin
        ev    = EV_ERR;
        val   = '0;
        pay   = '0;
        key_o = 1'b0;
        slast = 1'b0;
      end
    end
  end

  assign depth_ext = 16'(depth_nxt);

  always_comb begin
    res_nxt.event_res   = ev;
    res_nxt.value       = val;
    res_nxt.payload     = pay;
    res_nxt.depth       = depth_ext[5:0];
    res_nxt.is_key      = key_o;
    res_nxt.string_last = slast;
    unique case (mode_nxt)
      M_DONE:  res_nxt.status = ST_DONE;
      M_ERR:   res_nxt.status = ST_ERR;
      default: res_nxt.status = ST_BUSY;
    endcase
  end

  // ---------------------------------------------------------------------------
  // state registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_ELEM;
      depth_r <= '0;
    end else begin
      mode_r  <= mode_nxt;
      depth_r <= depth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r  <= top_nxt;
    acc_r  <= acc_nxt;
    neg_r  <= neg_nxt;
    rem_r  <= rem_nxt;
    skey_r <= skey_nxt;
  end

  // ---------------------------------------------------------------------------
  // result stage
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == M_ERR |=> mode_r == M_ERR)
    else $error("error state left without reset");

  a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == M_DONE |-> depth_r == '0)
    else $error("document complete with containers still open");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(MAX_DEPTH))
    else $error("nesting depth beyond limit");

  a_err_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status == ST_ERR |-> mode_r == M_ERR)
    else $error("error reported while parser not in error state");

endmodule
